FILE: rtl/trcr_pkg.sv
// Shared types and constants for the transport-protocol RTS/CTS receive session.
// Used by the front classifier, the item queue, the session back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package trcr_pkg;

   localparam logic [7:0] GLOBAL_ADDR   = 8'd255;
   localparam logic [7:0] CODE_RTS      = 8'd16;
   localparam logic [7:0] CODE_CTS      = 8'd17;
   localparam logic [7:0] CODE_ACK      = 8'd19;
   localparam logic [7:0] CODE_ABORT    = 8'd255;
   localparam logic [7:0] REASON_SEQ    = 8'd4;
   localparam logic [7:0] REASON_SIZE   = 8'd5;
   localparam logic [7:0] RESERVED_BYTE = 8'hff;
   localparam int         QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      CMD_CONTROL = 2'd0,
      CMD_DATA    = 2'd1,
      CMD_STEP    = 2'd2
   } cmd_type;

   // Classified operation handed from the front to the back end.
   typedef enum logic [2:0] {
      OP_NOP     = 3'd0,
      OP_RTS_OK  = 3'd1,
      OP_RTS_BAD = 3'd2,
      OP_ABORT   = 3'd3,
      OP_DATA    = 3'd4,
      OP_STEP    = 3'd5
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  dest;
      logic [7:0]  source;
      logic [7:0]  seq;
      logic [15:0] size;
      logic [7:0]  packets;
      logic [7:0]  limit;
      logic [23:0] group;
   } item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_dest;
      logic [7:0]  tx_byte0;
      logic [7:0]  tx_byte1;
      logic [7:0]  tx_byte2;
      logic [7:0]  tx_byte3;
      logic [7:0]  tx_byte4;
      logic [7:0]  tx_byte5;
      logic [7:0]  tx_byte6;
      logic [7:0]  tx_byte7;
      logic        session_active;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/tp_rts_cts_receive_session.sv
// RTS/CTS receive session, top level. A request passes through the item queue and then the
// back end's result register. Throughput: one request per cycle while no response is held,
// set by the session update in the back end. Stalls: a held response blocks the back end;
// QueueDepth more requests (two by default) fit in the queue, then req_tready drops. Every
// request gives exactly one response. Reset is synchronous and active high; it clears the
// queue, the response valid flag and all session registers (init state).
`timescale 1ns / 1ps
`default_nettype none

module tp_rts_cts_receive_session
   import trcr_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // request channel
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   // [7:0] frame_dest, [15:8] frame_source, [23:16] frame_byte0 ... [79:72] frame_byte7
   input  wire  logic [79:0] req_tdata,
   // [1:0] command
   input  wire  logic [1:0]  req_tuser,
   // response channel
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   // [7:0] tx_dest, [15:8] tx_byte0 ... [71:64] tx_byte7, [72] session_active, rest zero
   output logic [79:0]       rsp_tdata,
   // [0] tx_valid
   output logic              rsp_tuser
);

   item_type   front_item;
   item_type   queue_item;
   logic       queue_valid;
   logic       queue_ready;
   result_type result;

   // Front: classify each request into one session operation (RTS check done here).
   trcr_front u_front (
      .command      (req_tuser),
      .frame_dest   (req_tdata[7:0]),
      .frame_source (req_tdata[15:8]),
      .frame_byte0  (req_tdata[23:16]),
      .frame_byte1  (req_tdata[31:24]),
      .frame_byte2  (req_tdata[39:32]),
      .frame_byte3  (req_tdata[47:40]),
      .frame_byte4  (req_tdata[55:48]),
      .frame_byte5  (req_tdata[63:56]),
      .frame_byte6  (req_tdata[71:64]),
      .frame_byte7  (req_tdata[79:72]),
      .item         (front_item)
   );

   // Queue decouples request acceptance from response back-pressure.
   trcr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_item)
   );

   // Back end: session registers, state machine and the response register.
   trcr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (queue_valid),
      .item_ready   (queue_ready),
      .item         (queue_item),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tuser = result.tx_valid;
   assign rsp_tdata = {7'b0000000, result.session_active,
                       result.tx_byte7, result.tx_byte6, result.tx_byte5, result.tx_byte4,
                       result.tx_byte3, result.tx_byte2, result.tx_byte1, result.tx_byte0,
                       result.tx_dest};

endmodule

`default_nettype wire

FILE: rtl/trcr_front.sv
// Front end: decodes an incoming request and classifies it into one session operation.
// Depends on trcr_pkg. Pure decode; the RTS size check is resolved here.
`timescale 1ns / 1ps
`default_nettype none

module trcr_front
   import trcr_pkg::*;
(
   input  wire  logic [1:0]  command,
   input  wire  logic [7:0]  frame_dest,
   input  wire  logic [7:0]  frame_source,
   input  wire  logic [7:0]  frame_byte0,
   input  wire  logic [7:0]  frame_byte1,
   input  wire  logic [7:0]  frame_byte2,
   input  wire  logic [7:0]  frame_byte3,
   input  wire  logic [7:0]  frame_byte4,
   input  wire  logic [7:0]  frame_byte5,
   input  wire  logic [7:0]  frame_byte6,
   input  wire  logic [7:0]  frame_byte7,
   output item_type          item
);

   logic [15:0] size;
   logic [10:0] capacity;   // packets * 7 bytes
   logic        size_ok;

   assign size     = {frame_byte2, frame_byte1};
   assign capacity = {frame_byte3, 3'b000} - {3'b000, frame_byte3};
   assign size_ok  = size <= {5'b00000, capacity};

   always_comb begin
      item.dest    = frame_dest;
      item.source  = frame_source;
      item.seq     = frame_byte0;
      item.size    = size;
      item.packets = frame_byte3;
      item.limit   = frame_byte4;
      item.group   = {frame_byte7, frame_byte6, frame_byte5};
      item.op      = OP_NOP;
      unique case (command)
         CMD_CONTROL: begin
            if (frame_byte0 == CODE_RTS) begin
               // RTS to the global address is ignored
               if (frame_dest != GLOBAL_ADDR) begin
                  item.op = size_ok ? OP_RTS_OK : OP_RTS_BAD;
               end
            end else if (frame_byte0 == CODE_ABORT) begin
               item.op = OP_ABORT;
            end
         end
         CMD_DATA: item.op = OP_DATA;
         CMD_STEP: item.op = OP_STEP;
         default:  item.op = OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/trcr_queue.sv
// Small FIFO of classified items between the front and the session back end.
// Depends on trcr_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module trcr_queue
   import trcr_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire  logic     clock,
   input  wire  logic     reset,
   input  wire  logic     push_valid,
   output logic           push_ready,
   input  wire  item_type push_data,
   output logic           pop_valid,
   input  wire  logic     pop_ready,
   output item_type       pop_data
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   item_type            mem [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff != CountW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/trcr_back.sv
// Session back end: applies classified items to the session registers and state
// machine, and holds the result in an output register. Depends on trcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trcr_back
   import trcr_pkg::*;
(
   input  wire  logic     clock,
   input  wire  logic     reset,
   input  wire  logic     item_valid,
   output logic           item_ready,
   input  wire  item_type item,
   output logic           result_valid,
   input  wire  logic     result_ready,
   output result_type     result
);

   typedef enum logic [6:0] {
      ST_INIT          = 7'b0000001,
      ST_WAIT_RTS      = 7'b0000010,
      ST_COLLECT_START = 7'b0000100,
      ST_COLLECT       = 7'b0001000,
      ST_ABORTED       = 7'b0010000,
      ST_SEND_ABORT    = 7'b0100000,
      ST_SEND_COMPLETE = 7'b1000000
   } state_type;

   state_type   state_ff, state_in, step_state;
   logic        rts_ff, rts_in;
   logic        abort_seen_ff, abort_seen_in;
   logic        abort_pend_ff, abort_pend_in;
   logic [7:0]  reason_ff, reason_in;
   logic [23:0] group_ff, group_in;
   logic [15:0] size_ff, size_in;
   logic [7:0]  pkt_exp_ff, pkt_exp_in;
   logic [7:0]  pkt_rcv_ff, pkt_rcv_in;
   logic [7:0]  exp_seq_ff, exp_seq_in;
   logic [7:0]  limit_ff, limit_in;
   logic [7:0]  sess_dest_ff, sess_dest_in;
   logic [7:0]  sess_src_ff, sess_src_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        advance;
   logic        emit;
   logic [7:0]  emit_code, emit_b1, emit_b2, emit_b3;

   assign item_ready   = !rsp_valid_ff || result_ready;
   assign advance      = item_valid && item_ready;
   assign result_valid = rsp_valid_ff;
   assign result       = rsp_ff;
   // a pending abort overrides the current state on a step
   assign step_state   = abort_pend_ff ? ST_SEND_ABORT : state_ff;

   always_comb begin
      state_in      = state_ff;
      rts_in        = rts_ff;
      abort_seen_in = abort_seen_ff;
      abort_pend_in = abort_pend_ff;
      reason_in     = reason_ff;
      group_in      = group_ff;
      size_in       = size_ff;
      pkt_exp_in    = pkt_exp_ff;
      pkt_rcv_in    = pkt_rcv_ff;
      exp_seq_in    = exp_seq_ff;
      limit_in      = limit_ff;
      sess_dest_in  = sess_dest_ff;
      sess_src_in   = sess_src_ff;
      emit          = 1'b0;
      emit_code     = '0;
      emit_b1       = '0;
      emit_b2       = '0;
      emit_b3       = '0;
      unique case (item.op)
         OP_RTS_OK: begin
            rts_in       = 1'b1;
            group_in     = item.group;
            size_in      = item.size;
            pkt_exp_in   = item.packets;
            exp_seq_in   = 8'd1;
            limit_in     = item.limit;
            sess_dest_in = item.dest;
            sess_src_in  = item.source;
         end
         OP_RTS_BAD: begin
            abort_pend_in = 1'b1;
            reason_in     = REASON_SIZE;
         end
         OP_ABORT: abort_seen_in = 1'b1;
         OP_DATA: begin
            if (item.dest == sess_dest_ff && item.source == sess_src_ff) begin
               if (item.seq != exp_seq_ff) begin
                  abort_pend_in = 1'b1;
                  reason_in     = REASON_SEQ;
               end else begin
                  pkt_rcv_in = pkt_rcv_ff + 8'd1;
                  exp_seq_in = exp_seq_ff + 8'd1;
               end
            end
         end
         OP_STEP: begin
            abort_pend_in = 1'b0;
            state_in      = step_state;
            unique case (step_state)
               ST_WAIT_RTS: begin
                  if (rts_ff) begin
                     state_in  = ST_COLLECT_START;
                     rts_in    = 1'b0;
                     emit      = 1'b1;
                     emit_code = CODE_CTS;
                     emit_b1   = limit_ff;
                     emit_b2   = exp_seq_ff;
                     emit_b3   = RESERVED_BYTE;
                  end
               end
               ST_COLLECT_START: state_in = ST_COLLECT;
               ST_COLLECT: begin
                  if (pkt_rcv_ff >= pkt_exp_ff) begin
                     state_in = ST_SEND_COMPLETE;
                  end
                  if (abort_seen_ff) begin
                     abort_seen_in = 1'b0;
                     state_in      = ST_ABORTED;
                  end
               end
               ST_ABORTED: state_in = ST_INIT;
               ST_SEND_ABORT: begin
                  state_in  = ST_INIT;
                  emit      = 1'b1;
                  emit_code = CODE_ABORT;
                  emit_b1   = reason_ff;
                  emit_b2   = RESERVED_BYTE;
                  emit_b3   = RESERVED_BYTE;
               end
               ST_SEND_COMPLETE: begin
                  state_in  = ST_INIT;
                  emit      = 1'b1;
                  emit_code = CODE_ACK;
                  emit_b1   = size_ff[7:0];
                  emit_b2   = size_ff[15:8];
                  emit_b3   = pkt_exp_ff;
               end
               default: begin
                  // init: clear the session and wait for an RTS
                  rts_in        = 1'b0;
                  pkt_rcv_in    = '0;
                  exp_seq_in    = 8'd1;
                  pkt_exp_in    = '0;
                  abort_seen_in = 1'b0;
                  state_in      = ST_WAIT_RTS;
               end
            endcase
         end
         default: ;
      endcase

      rsp_in.tx_valid       = emit;
      rsp_in.tx_dest        = emit ? sess_src_ff : '0;
      rsp_in.tx_byte0       = emit_code;
      rsp_in.tx_byte1       = emit_b1;
      rsp_in.tx_byte2       = emit_b2;
      rsp_in.tx_byte3       = emit_b3;
      rsp_in.tx_byte4       = emit ? RESERVED_BYTE : '0;
      rsp_in.tx_byte5       = emit ? group_ff[7:0] : '0;
      rsp_in.tx_byte6       = emit ? group_ff[15:8] : '0;
      rsp_in.tx_byte7       = emit ? group_ff[23:16] : '0;
      rsp_in.session_active = state_in != ST_WAIT_RTS;

      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !result_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         rts_ff        <= 1'b0;
         abort_seen_ff <= 1'b0;
         abort_pend_ff <= 1'b0;
         reason_ff     <= '0;
         group_ff      <= '0;
         size_ff       <= '0;
         pkt_exp_ff    <= '0;
         pkt_rcv_ff    <= '0;
         exp_seq_ff    <= '0;
         limit_ff      <= '0;
         sess_dest_ff  <= '0;
         sess_src_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff      <= state_in;
            rts_ff        <= rts_in;
            abort_seen_ff <= abort_seen_in;
            abort_pend_ff <= abort_pend_in;
            reason_ff     <= reason_in;
            group_ff      <= group_in;
            size_ff       <= size_in;
            pkt_exp_ff    <= pkt_exp_in;
            pkt_rcv_ff    <= pkt_rcv_in;
            exp_seq_ff    <= exp_seq_in;
            limit_ff      <= limit_in;
            sess_dest_ff  <= sess_dest_in;
            sess_src_ff   <= sess_src_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
